// ----- src/sed_pkg.sv -----
// shared types and constants of the string escape decoder
package sed_pkg;

   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_NEWLINE      = 4'd1;
   localparam logic [3:0] ERR_BAD_HEX      = 4'd2;
   localparam logic [3:0] ERR_NO_BRACE     = 4'd3;
   localparam logic [3:0] ERR_TOO_LARGE    = 4'd4;
   localparam logic [3:0] ERR_BAD_U        = 4'd5;
   localparam logic [3:0] ERR_DEC_RANGE    = 4'd6;
   localparam logic [3:0] ERR_UNKNOWN_ESC  = 4'd7;
   localparam logic [3:0] ERR_UNTERMINATED = 4'd8;
   localparam logic [3:0] ERR_BAD_OPENER   = 4'd9;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       literal_done;
      logic [3:0] error_code;
   } rsp_type;

   // one result before its position in the run is known
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       literal_done;
      logic [3:0] error_code;
   } entry_type;

   // all results caused by one item
   typedef struct packed {
      entry_type [MAX_RESULTS-1:0] ent;
      logic [CNT_W-1:0]            count;
   } bundle_type;

endpackage

// ----- src/sed_step.sv -----
// decoder state register and the per-byte decode logic
module sed_step
   import sed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    item,
   input  logic       advance,
   output bundle_type bundle
);

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_BODY     = 4'd1,
      PH_ESC      = 4'd2,
      PH_HEX1     = 4'd3,
      PH_HEX2     = 4'd4,
      PH_ZSKIP    = 4'd5,
      PH_AFTER_CR = 4'd6,
      PH_AFTER_LF = 4'd7,
      PH_U_OPEN   = 4'd8,
      PH_U_DIGITS = 4'd9,
      PH_DEC      = 4'd10
   } phase_type;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   phase_type   phase_ff, phase_in;
   logic        quote_ff, quote_in;
   logic [30:0] acc_ff, acc_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic        seen_ff, seen_in;

   // bit 4 flags a hex digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_value(input logic [7:0] v);
      logic [4:0] r;
      r = '0;
      if (v inside {[8'h30:8'h39]}) begin
         r = {1'b1, v[3:0]};
      end else if (v inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r = {1'b1, v[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic entry_type ent_byte(input logic [7:0] v);
      return '{out_byte: v, byte_valid: 1'b1, literal_done: 1'b0, error_code: ERR_NONE};
   endfunction

   always_comb begin
      logic [CNT_W-1:0] n;
      logic             body;
      logic             fail;
      logic             done;
      logic [3:0]       fcode;
      logic [4:0]       hx;
      logic [9:0]       dec;
      logic [7:0]       b;
      logic             eot;
      logic [7:0]       q;
      logic [30:0]      cp;

      b     = item.src_byte;
      eot   = item.end_of_text;
      n     = '0;
      body  = 1'b0;
      fail  = 1'b0;
      done  = 1'b0;
      fcode = ERR_NONE;
      hx    = hex_value(b);
      dec   = 10'(acc_ff[6:0]) * 10'd10 + 10'(b[3:0]);
      q     = quote_ff ? CH_SQUOTE : CH_DQUOTE;
      cp    = acc_ff;
      bundle.ent = '0;

      phase_in = phase_ff;
      quote_in = quote_ff;
      acc_in   = acc_ff;
      dcnt_in  = dcnt_ff;
      seen_in  = seen_ff;

      case (phase_ff)
         PH_BODY: begin
            body = 1'b1;
         end
         PH_ESC: begin
            if (eot) begin
               fail  = 1'b1;
               fcode = ERR_UNTERMINATED;
            end else begin
               phase_in = PH_BODY;
               case (b)
                  8'h6E: begin bundle.ent[n] = ent_byte(CH_LF); n = n + 1'b1; end
                  8'h74: begin bundle.ent[n] = ent_byte(8'h09); n = n + 1'b1; end
                  8'h72: begin bundle.ent[n] = ent_byte(CH_CR); n = n + 1'b1; end
                  8'h61: begin bundle.ent[n] = ent_byte(8'h07); n = n + 1'b1; end
                  8'h62: begin bundle.ent[n] = ent_byte(8'h08); n = n + 1'b1; end
                  8'h66: begin bundle.ent[n] = ent_byte(8'h0C); n = n + 1'b1; end
                  8'h76: begin bundle.ent[n] = ent_byte(8'h0B); n = n + 1'b1; end
                  CH_BSLASH, CH_DQUOTE, CH_SQUOTE: begin
                     bundle.ent[n] = ent_byte(b);
                     n = n + 1'b1;
                  end
                  8'h78: phase_in = PH_HEX1;
                  8'h7A: phase_in = PH_ZSKIP;
                  8'h75: phase_in = PH_U_OPEN;
                  CH_LF: begin
                     bundle.ent[n] = ent_byte(CH_LF);
                     n = n + 1'b1;
                     phase_in = PH_AFTER_LF;
                  end
                  CH_CR: begin
                     bundle.ent[n] = ent_byte(CH_LF);
                     n = n + 1'b1;
                     phase_in = PH_AFTER_CR;
                  end
                  default: begin
                     if (b inside {[8'h30:8'h39]}) begin
                        acc_in   = 31'(b[3:0]);
                        dcnt_in  = 2'd1;
                        phase_in = PH_DEC;
                     end else begin
                        fail  = 1'b1;
                        fcode = ERR_UNKNOWN_ESC;
                     end
                  end
               endcase
            end
         end
         PH_HEX1: begin
            if (eot || !hx[4]) begin
               fail  = 1'b1;
               fcode = ERR_BAD_HEX;
            end else begin
               acc_in   = 31'(hx[3:0]);
               phase_in = PH_HEX2;
            end
         end
         PH_HEX2: begin
            if (eot || !hx[4]) begin
               fail  = 1'b1;
               fcode = ERR_BAD_HEX;
            end else begin
               bundle.ent[n] = ent_byte({acc_ff[3:0], hx[3:0]});
               n = n + 1'b1;
               acc_in   = '0;
               phase_in = PH_BODY;
            end
         end
         PH_ZSKIP: begin
            if (eot || !(b == 8'h20 || b inside {[8'h09:8'h0D]})) begin
               body = 1'b1;
            end
         end
         PH_AFTER_CR, PH_AFTER_LF: begin
            // the other half of a CR LF or LF CR pair is swallowed
            if (!eot && b == ((phase_ff == PH_AFTER_CR) ? CH_LF : CH_CR)) begin
               phase_in = PH_BODY;
            end else begin
               body = 1'b1;
            end
         end
         PH_U_OPEN: begin
            if (eot || b != CH_LBRACE) begin
               fail  = 1'b1;
               fcode = ERR_NO_BRACE;
            end else begin
               acc_in   = '0;
               seen_in  = 1'b0;
               phase_in = PH_U_DIGITS;
            end
         end
         PH_U_DIGITS: begin
            if (!eot && hx[4]) begin
               if (acc_ff[30:27] != 4'd0) begin
                  fail  = 1'b1;
                  fcode = ERR_TOO_LARGE;
               end else begin
                  acc_in  = {acc_ff[26:0], hx[3:0]};
                  seen_in = 1'b1;
               end
            end else if (!eot && b == CH_RBRACE && seen_ff) begin
               // utf-8 with up to six bytes
               if (cp < 31'h80) begin
                  bundle.ent[0] = ent_byte(cp[7:0]);
                  n = 3'd1;
               end else if (cp < 31'h800) begin
                  bundle.ent[0] = ent_byte({3'b110, cp[10:6]});
                  bundle.ent[1] = ent_byte({2'b10, cp[5:0]});
                  n = 3'd2;
               end else if (cp < 31'h10000) begin
                  bundle.ent[0] = ent_byte({4'b1110, cp[15:12]});
                  bundle.ent[1] = ent_byte({2'b10, cp[11:6]});
                  bundle.ent[2] = ent_byte({2'b10, cp[5:0]});
                  n = 3'd3;
               end else if (cp < 31'h200000) begin
                  bundle.ent[0] = ent_byte({5'b11110, cp[20:18]});
                  bundle.ent[1] = ent_byte({2'b10, cp[17:12]});
                  bundle.ent[2] = ent_byte({2'b10, cp[11:6]});
                  bundle.ent[3] = ent_byte({2'b10, cp[5:0]});
                  n = 3'd4;
               end else if (cp < 31'h4000000) begin
                  bundle.ent[0] = ent_byte({6'b111110, cp[25:24]});
                  bundle.ent[1] = ent_byte({2'b10, cp[23:18]});
                  bundle.ent[2] = ent_byte({2'b10, cp[17:12]});
                  bundle.ent[3] = ent_byte({2'b10, cp[11:6]});
                  bundle.ent[4] = ent_byte({2'b10, cp[5:0]});
                  n = 3'd5;
               end else begin
                  bundle.ent[0] = ent_byte({7'b1111110, cp[30]});
                  bundle.ent[1] = ent_byte({2'b10, cp[29:24]});
                  bundle.ent[2] = ent_byte({2'b10, cp[23:18]});
                  bundle.ent[3] = ent_byte({2'b10, cp[17:12]});
                  bundle.ent[4] = ent_byte({2'b10, cp[11:6]});
                  bundle.ent[5] = ent_byte({2'b10, cp[5:0]});
                  n = 3'd6;
               end
               acc_in   = '0;
               seen_in  = 1'b0;
               phase_in = PH_BODY;
            end else begin
               fail  = 1'b1;
               fcode = ERR_BAD_U;
            end
         end
         PH_DEC: begin
            if (!eot && b inside {[8'h30:8'h39]} && dcnt_ff != 2'd3) begin
               acc_in  = 31'(dec);
               dcnt_in = dcnt_ff + 2'd1;
               // third digit closes the escape
               if (dcnt_ff == 2'd2) begin
                  if (dec > 10'd255) begin
                     fail  = 1'b1;
                     fcode = ERR_DEC_RANGE;
                  end else begin
                     bundle.ent[n] = ent_byte(dec[7:0]);
                     n = n + 1'b1;
                     acc_in   = '0;
                     dcnt_in  = '0;
                     phase_in = PH_BODY;
                  end
               end
            end else if (acc_ff > 31'd255) begin
               fail  = 1'b1;
               fcode = ERR_DEC_RANGE;
            end else begin
               // pending value goes out before the byte that ended it
               bundle.ent[n] = ent_byte(acc_ff[7:0]);
               n = n + 1'b1;
               acc_in  = '0;
               dcnt_in = '0;
               body    = 1'b1;
            end
         end
         default: begin
            acc_in   = '0;
            dcnt_in  = '0;
            seen_in  = 1'b0;
            phase_in = PH_IDLE;
            if (!eot) begin
               if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                  quote_in = (b == CH_SQUOTE);
                  phase_in = PH_BODY;
               end else begin
                  fail  = 1'b1;
                  fcode = ERR_BAD_OPENER;
               end
            end
         end
      endcase

      if (body) begin
         phase_in = PH_BODY;
         if (eot) begin
            fail  = 1'b1;
            fcode = ERR_UNTERMINATED;
         end else if (b == q) begin
            done = 1'b1;
         end else if (b == CH_LF || b == CH_CR) begin
            fail  = 1'b1;
            fcode = ERR_NEWLINE;
         end else if (b == CH_BSLASH) begin
            phase_in = PH_ESC;
         end else begin
            bundle.ent[n] = ent_byte(b);
            n = n + 1'b1;
         end
      end

      if (fail || done) begin
         bundle.ent[n] = '{out_byte: 8'h00, byte_valid: 1'b0, literal_done: done,
                           error_code: fcode};
         n = n + 1'b1;
         phase_in = PH_IDLE;
         acc_in   = '0;
         dcnt_in  = '0;
         seen_in  = 1'b0;
      end

      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         quote_ff <= 1'b0;
         acc_ff   <= '0;
         dcnt_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         quote_ff <= quote_in;
         acc_ff   <= acc_in;
         dcnt_ff  <= dcnt_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ----- src/sed_outbuf.sv -----
// result register that holds one item's results and hands them out one per transfer
module sed_outbuf
   import sed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   entry_type [MAX_RESULTS-1:0] ent_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            idx_ff;
   logic                        last;
   entry_type                   cur;

   assign cur       = ent_ff[idx_ff];
   assign last      = (idx_ff == cnt_ff - 1'b1);
   assign rsp_valid = (cnt_ff != '0);
   // empty now, or the last result leaves in this cycle
   assign free      = !rsp_valid || (rsp_ready && last);

   assign rsp_data = '{out_byte:     cur.out_byte,
                       byte_valid:   cur.byte_valid,
                       last_of_run:  last,
                       literal_done: cur.literal_done,
                       error_code:   cur.error_code};

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= bundle.ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (load) begin
         cnt_ff <= bundle.count;
         idx_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         if (last) begin
            cnt_ff <= '0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

`ifndef SYNTH
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < cnt_ff) && (cnt_ff <= CNT_W'(MAX_RESULTS)))
      else $error("result index outside the held run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=> rsp_valid)
      else $error("run ended without its last result");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.literal_done || rsp_data.error_code != ERR_NONE)
         |-> !rsp_data.byte_valid && rsp_data.last_of_run)
      else $error("done or error result carries a byte or is not last");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free && bundle.count != '0)
      else $error("results loaded over a run still in flight");
`endif

endmodule

// ----- src/string_escape_decoder_top.sv -----
// top level of the quoted string literal escape decoder
// Decodes one quoted literal from source bytes, one byte per req_ transfer, the
// first byte being the opening quote. Each item yields zero to six rsp_ results:
// decoded bytes, a done result on the closing quote, or an error result, after
// which the block is idle again; last_of_run marks the final result of an item.
// Items pass an input register, the decode logic and a result register, so the
// first result is offered on rsp_ from the result register and can leave while
// rsp_ready is high. The block takes one item per cycle as long as each item
// yields at most one result and rsp_ready stays high; an item that yields more
// than one result holds the result register until its last result leaves (up to
// six for a \u{...} escape emitted as UTF-8), and the next item that yields
// results waits in the input register while req_ready is low.
module string_escape_decoder_top
   import sed_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       in_vld_ff;
   req_type    in_ff;
   bundle_type bundle;
   logic       free;
   logic       advance;
   logic       load;

   // an item with no results never waits on the result register
   assign advance   = in_vld_ff && (bundle.count == '0 || free);
   assign load      = advance && bundle.count != '0;
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   sed_step u_step (
      .clock   (clock),
      .reset   (reset),
      .item    (in_ff),
      .advance (advance),
      .bundle  (bundle)
   );

   sed_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
